>>> rtl/atapio_pkg.sv
`timescale 1ns / 1ps

package atapio_pkg;

    localparam int WORDS_PER_SECTOR = 256;
    localparam int WORD_W = (WORDS_PER_SECTOR > 1) ? $clog2(WORDS_PER_SECTOR) : 1;
    localparam int MAX_RESULTS = 8;
    localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);
    localparam int RES_IDX_W = $clog2(MAX_RESULTS);

    localparam logic [15:0] TIMEOUT_RESET = 16'd300;
    localparam logic [7:0]  HOLD_RESET    = 8'd10;

    localparam logic [9:0] PRIMARY_BASE   = 10'h1F0;
    localparam logic [9:0] SECONDARY_BASE = 10'h170;
    localparam logic [9:0] CTRL_OFFSET    = 10'h206;
    localparam logic [9:0] REG_COUNT      = 10'd2;
    localparam logic [9:0] REG_LBA_LO     = 10'd3;
    localparam logic [9:0] REG_LBA_MID    = 10'd4;
    localparam logic [9:0] REG_LBA_HI     = 10'd5;
    localparam logic [9:0] REG_DEVICE     = 10'd6;
    localparam logic [9:0] REG_CMD_STAT   = 10'd7;

    localparam logic [7:0] ST_BSY = 8'h80;
    localparam logic [7:0] ST_RDY = 8'h40;
    localparam logic [7:0] ST_DRQ = 8'h08;
    localparam logic [7:0] ST_ERR = 8'h01;

    localparam logic [7:0] DEV_BASE  = 8'hE0;
    localparam logic [7:0] DEV_SLAVE = 8'h10;

    localparam logic [7:0] CMD_READ  = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;
    localparam logic [7:0] CTRL_SRST = 8'h04;

    localparam logic [1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [1:0] CFG_HOLD    = 2'd1;

    typedef enum logic [2:0] {
        OP_REQUEST = 3'd0,
        OP_STATUS  = 3'd1,
        OP_RD_WORD = 3'd2,
        OP_WR_WORD = 3'd3,
        OP_TICK    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        KIND_BUS_WR  = 3'd0,
        KIND_STAT_RD = 3'd1,
        KIND_DATA_RD = 3'd2,
        KIND_TO_HOST = 3'd3,
        KIND_DONE    = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE        = 4'd0,
        PH_BSY0_POLL   = 4'd1,
        PH_BSY0_SLEEP  = 4'd2,
        PH_RDY_POLL    = 4'd3,
        PH_RDY_SLEEP   = 4'd4,
        PH_DRQ_POLL    = 4'd5,
        PH_DRQ_SLEEP   = 4'd6,
        PH_END_POLL    = 4'd7,
        PH_END_SLEEP   = 4'd8,
        PH_RD_DATA     = 4'd9,
        PH_WR_DATA     = 4'd10,
        PH_RST_ASSERT  = 4'd11,
        PH_RST_RELEASE = 4'd12
    } phase_t;

    typedef struct packed {
        logic [2:0]  op;
        logic        is_write;
        logic [1:0]  drive;
        logic [27:0] lba;
        logic [7:0]  sector_count;
        logic [7:0]  status;
        logic [15:0] data;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [9:0]  port;
        logic [15:0] value;
        logic        success;
        logic [7:0]  sectors_done;
    } res_t;

    typedef res_t [MAX_RESULTS-1:0] res_list_t;

    function automatic res_t mk_res(kind_t k, logic [9:0] p, logic [15:0] v,
                                    logic ok, logic [7:0] secs);
        res_t r;
        r.kind = k;
        r.port = p;
        r.value = v;
        r.success = ok;
        r.sectors_done = secs;
        return r;
    endfunction

    function automatic logic [9:0] base_of(logic [1:0] drv);
        return drv[1] ? SECONDARY_BASE : PRIMARY_BASE;
    endfunction

    function automatic logic [7:0] sel_byte(logic [1:0] drv, logic [27:0] addr);
        return DEV_BASE | (drv[0] ? DEV_SLAVE : 8'h00) | {4'h0, addr[27:24]};
    endfunction

endpackage

>>> rtl/atapio_in_reg.sv
`timescale 1ns / 1ps

module atapio_in_reg
    import atapio_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic        is_write,
    input  logic [1:0]  drive,
    input  logic [27:0] lba,
    input  logic [7:0]  sector_count,
    input  logic [7:0]  status,
    input  logic [15:0] data,
    input  logic        take,
    output logic        held_valid,
    output item_t       held_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{op: op, is_write: is_write, drive: drive, lba: lba,
                          sector_count: sector_count, status: status, data: data};
        end
    end

endmodule

>>> rtl/atapio_seq.sv
`timescale 1ns / 1ps

module atapio_seq
    import atapio_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 take,
    input  item_t                itm,
    output res_list_t            res_list,
    output logic [RES_CNT_W-1:0] res_n
);

    phase_t            phase_reg, phase_next;
    logic [1:0]        drive_reg, drive_next;
    logic [27:0]       lba_reg, lba_next;
    logic [7:0]        count_reg, count_next;
    logic              dir_reg, dir_next;
    logic [15:0]       timer_reg, timer_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [7:0]        sector_reg, sector_next;
    logic [15:0]       timeout_reg, timeout_next;
    logic [7:0]        hold_reg, hold_next;

    always_comb
    begin
        logic [9:0]           b;
        logic [7:0]           mask;
        logic [7:0]           want;
        logic                 polling;
        logic [15:0]          t_inc;
        logic [7:0]           sec_inc;
        logic [RES_CNT_W-1:0] n;
        res_list_t            lst;

        phase_next   = phase_reg;
        drive_next   = drive_reg;
        lba_next     = lba_reg;
        count_next   = count_reg;
        dir_next     = dir_reg;
        timer_next   = timer_reg;
        word_next    = word_reg;
        sector_next  = sector_reg;
        timeout_next = timeout_reg;
        hold_next    = hold_reg;
        n            = '0;
        lst          = '0;

        b       = base_of(drive_reg);
        t_inc   = (timer_reg == 16'hFFFF) ? timer_reg : timer_reg + 16'd1;
        sec_inc = sector_reg + 8'd1;

        polling = 1'b1;
        mask    = 8'h00;
        want    = 8'h00;
        case (phase_reg)
            PH_BSY0_POLL: mask = ST_BSY;
            PH_RDY_POLL:
            begin
                mask = ST_BSY | ST_RDY;
                want = ST_RDY;
            end
            PH_DRQ_POLL:
            begin
                mask = ST_DRQ;
                want = ST_DRQ;
            end
            PH_END_POLL: mask = ST_BSY;
            default: polling = 1'b0;
        endcase

        if (cfg_write)
        begin
            case (cfg_index)
                CFG_TIMEOUT: timeout_next = cfg_data;
                CFG_HOLD:    hold_next = cfg_data[7:0];
                default:     ;
            endcase
        end

        if (take)
        begin
            case (itm.op)
                OP_REQUEST:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        dir_next    = itm.is_write;
                        drive_next  = itm.drive;
                        lba_next    = itm.lba;
                        count_next  = itm.sector_count;
                        word_next   = '0;
                        sector_next = '0;
                        timer_next  = '0;
                        phase_next  = PH_BSY0_POLL;
                        lst[n[RES_IDX_W-1:0]] = mk_res(KIND_STAT_RD,
                            base_of(itm.drive) + REG_CMD_STAT, 16'h0, 1'b0, 8'h0);
                        n = n + 1'b1;
                    end
                end
                OP_STATUS:
                begin
                    if (polling)
                    begin
                        if ((itm.status & mask) == want)
                        begin
                            case (phase_reg)
                                PH_BSY0_POLL:
                                begin
                                    lst[n[RES_IDX_W-1:0]] = mk_res(KIND_BUS_WR, b + REG_DEVICE,
                                        {8'h0, sel_byte(drive_reg, lba_reg)}, 1'b0, 8'h0);
                                    n = n + 1'b1;
                                    timer_next = '0;
                                    phase_next = PH_RDY_POLL;
                                    lst[n[RES_IDX_W-1:0]] = mk_res(KIND_STAT_RD,
                                        b + REG_CMD_STAT, 16'h0, 1'b0, 8'h0);
                                    n = n + 1'b1;
                                end
                                PH_RDY_POLL:
                                begin
                                    // device control and task file, then the command byte and a status read
                                    lst[0] = mk_res(KIND_BUS_WR, b + CTRL_OFFSET, 16'h0,
                                        1'b0, 8'h0);
                                    lst[1] = mk_res(KIND_BUS_WR, b + REG_COUNT,
                                        {8'h0, count_reg}, 1'b0, 8'h0);
                                    lst[2] = mk_res(KIND_BUS_WR, b + REG_LBA_LO,
                                        {8'h0, lba_reg[7:0]}, 1'b0, 8'h0);
                                    lst[3] = mk_res(KIND_BUS_WR, b + REG_LBA_MID,
                                        {8'h0, lba_reg[15:8]}, 1'b0, 8'h0);
                                    lst[4] = mk_res(KIND_BUS_WR, b + REG_LBA_HI,
                                        {8'h0, lba_reg[23:16]}, 1'b0, 8'h0);
                                    lst[5] = mk_res(KIND_BUS_WR, b + REG_DEVICE,
                                        {8'h0, sel_byte(drive_reg, lba_reg)}, 1'b0, 8'h0);
                                    lst[6] = mk_res(KIND_BUS_WR, b + REG_CMD_STAT,
                                        {8'h0, dir_reg ? CMD_WRITE : CMD_READ}, 1'b0, 8'h0);
                                    lst[7] = mk_res(KIND_STAT_RD, b + REG_CMD_STAT, 16'h0,
                                        1'b0, 8'h0);
                                    n = RES_CNT_W'(MAX_RESULTS);
                                    sector_next = '0;
                                    word_next   = '0;
                                    timer_next  = '0;
                                    phase_next  = (count_reg == 8'h0) ? PH_END_POLL : PH_DRQ_POLL;
                                end
                                PH_DRQ_POLL:
                                begin
                                    word_next = '0;
                                    if (dir_reg)
                                    begin
                                        phase_next = PH_WR_DATA;
                                    end
                                    else
                                    begin
                                        phase_next = PH_RD_DATA;
                                        lst[n[RES_IDX_W-1:0]] = mk_res(KIND_DATA_RD, b, 16'h0,
                                            1'b0, 8'h0);
                                        n = n + 1'b1;
                                    end
                                end
                                default:
                                begin
                                    lst[n[RES_IDX_W-1:0]] = mk_res(KIND_DONE, 10'h0, 16'h0,
                                        1'b1, count_reg);
                                    n = n + 1'b1;
                                    phase_next = PH_IDLE;
                                end
                            endcase
                        end
                        else if ((itm.status & ST_ERR) != 8'h0 || timer_reg >= timeout_reg)
                        begin
                            // soft reset pulse; a zero hold finishes it at once
                            lst[n[RES_IDX_W-1:0]] = mk_res(KIND_BUS_WR, b + CTRL_OFFSET,
                                {8'h0, CTRL_SRST}, 1'b0, 8'h0);
                            n = n + 1'b1;
                            timer_next = '0;
                            if (hold_reg == 8'h0)
                            begin
                                lst[n[RES_IDX_W-1:0]] = mk_res(KIND_BUS_WR, b + CTRL_OFFSET,
                                    16'h0, 1'b0, 8'h0);
                                n = n + 1'b1;
                                lst[n[RES_IDX_W-1:0]] = mk_res(KIND_DONE, 10'h0, 16'h0,
                                    1'b0, 8'h0);
                                n = n + 1'b1;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next = PH_RST_ASSERT;
                            end
                        end
                        else
                        begin
                            phase_next = phase_t'(phase_reg + 4'd1);
                        end
                    end
                end
                OP_RD_WORD, OP_WR_WORD:
                begin
                    if ((itm.op == OP_RD_WORD && phase_reg == PH_RD_DATA) ||
                        (itm.op == OP_WR_WORD && phase_reg == PH_WR_DATA))
                    begin
                        lst[n[RES_IDX_W-1:0]] = mk_res(
                            (itm.op == OP_RD_WORD) ? KIND_TO_HOST : KIND_BUS_WR,
                            b, itm.data, 1'b0, 8'h0);
                        n = n + 1'b1;
                        if (word_reg != WORD_W'(WORDS_PER_SECTOR - 1))
                        begin
                            word_next = word_reg + 1'b1;
                            if (!dir_reg)
                            begin
                                lst[n[RES_IDX_W-1:0]] = mk_res(KIND_DATA_RD, b, 16'h0,
                                    1'b0, 8'h0);
                                n = n + 1'b1;
                            end
                        end
                        else
                        begin
                            word_next   = '0;
                            sector_next = sec_inc;
                            timer_next  = '0;
                            phase_next  = (sec_inc >= count_reg) ? PH_END_POLL : PH_DRQ_POLL;
                            lst[n[RES_IDX_W-1:0]] = mk_res(KIND_STAT_RD, b + REG_CMD_STAT,
                                16'h0, 1'b0, 8'h0);
                            n = n + 1'b1;
                        end
                    end
                end
                OP_TICK:
                begin
                    case (phase_reg)
                        PH_BSY0_SLEEP, PH_RDY_SLEEP, PH_DRQ_SLEEP, PH_END_SLEEP:
                        begin
                            timer_next = t_inc;
                            phase_next = phase_t'(phase_reg - 4'd1);
                            lst[n[RES_IDX_W-1:0]] = mk_res(KIND_STAT_RD, b + REG_CMD_STAT,
                                16'h0, 1'b0, 8'h0);
                            n = n + 1'b1;
                        end
                        PH_RST_ASSERT:
                        begin
                            timer_next = t_inc;
                            if (t_inc >= {8'h0, hold_reg})
                            begin
                                lst[n[RES_IDX_W-1:0]] = mk_res(KIND_BUS_WR, b + CTRL_OFFSET,
                                    16'h0, 1'b0, 8'h0);
                                n = n + 1'b1;
                                timer_next = '0;
                                if (hold_reg == 8'h0)
                                begin
                                    lst[n[RES_IDX_W-1:0]] = mk_res(KIND_DONE, 10'h0, 16'h0,
                                        1'b0, 8'h0);
                                    n = n + 1'b1;
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    phase_next = PH_RST_RELEASE;
                                end
                            end
                        end
                        PH_RST_RELEASE:
                        begin
                            timer_next = t_inc;
                            if (t_inc >= {8'h0, hold_reg})
                            begin
                                lst[n[RES_IDX_W-1:0]] = mk_res(KIND_DONE, 10'h0, 16'h0,
                                    1'b0, 8'h0);
                                n = n + 1'b1;
                                phase_next = PH_IDLE;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end

        res_list = lst;
        res_n    = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            drive_reg   <= '0;
            lba_reg     <= '0;
            count_reg   <= '0;
            dir_reg     <= 1'b0;
            timer_reg   <= '0;
            word_reg    <= '0;
            sector_reg  <= '0;
            timeout_reg <= TIMEOUT_RESET;
            hold_reg    <= HOLD_RESET;
        end
        else
        begin
            phase_reg   <= phase_next;
            drive_reg   <= drive_next;
            lba_reg     <= lba_next;
            count_reg   <= count_next;
            dir_reg     <= dir_next;
            timer_reg   <= timer_next;
            word_reg    <= word_next;
            sector_reg  <= sector_next;
            timeout_reg <= timeout_next;
            hold_reg    <= hold_next;
        end
    end

endmodule

>>> rtl/atapio_res_buf.sv
`timescale 1ns / 1ps

module atapio_res_buf
    import atapio_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  res_list_t            load_list,
    input  logic [RES_CNT_W-1:0] load_n,
    output logic                 free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output res_t                 head,
    output logic                 head_last
);

    res_list_t            entries_reg, entries_next;
    logic [RES_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 drain;

    assign drain     = out_valid && out_ready;
    assign out_valid = (cnt_reg != '0);
    assign free      = (cnt_reg == '0) || (cnt_reg == RES_CNT_W'(1) && out_ready);
    assign head      = entries_reg[0];
    assign head_last = (cnt_reg == RES_CNT_W'(1));

    always_comb
    begin
        entries_next = entries_reg;
        cnt_next     = cnt_reg;
        if (load)
        begin
            entries_next = load_list;
            cnt_next     = load_n;
        end
        else if (drain)
        begin
            // shift towards the head
            for (int i = 0; i < MAX_RESULTS - 1; i++)
            begin
                entries_next[i] = entries_reg[i+1];
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
    end

endmodule

>>> rtl/ata_pio_command_sequencer_core.sv
`timescale 1ns / 1ps
// channel  | handshake            | payload
// in       | in_valid / in_ready  | op is_write drive lba sector_count status data
// out      | out_valid / out_ready| kind port value success sectors_done last
// cfg      | cfg_valid / cfg_ready| cfg_index cfg_data
//
// one item a cycle while the buffer is free: the input register holds an item, then the
// sequencer step runs and its results (up to eight) load the output buffer in one go
// while out_ready is high the buffer hands out one result per cycle, so an item that makes
// one result or none flows every cycle; one with more holds the next until its last drains
// reset clears the phase, the request state and the buffer, and loads the register defaults
// a stalled output holds the buffer; the input register still takes one more item

module ata_pio_command_sequencer_core
    import atapio_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic        is_write,
    input  logic [1:0]  drive,
    input  logic [27:0] lba,
    input  logic [7:0]  sector_count,
    input  logic [7:0]  status,
    input  logic [15:0] data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [9:0]  port,
    output logic [15:0] value,
    output logic        success,
    output logic [7:0]  sectors_done,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic                 held_valid;
    item_t                held_item;
    logic                 take;
    logic                 buf_free;
    res_list_t            res_list;
    logic [RES_CNT_W-1:0] res_n;
    res_t                 head;

    assign cfg_ready = 1'b1;
    assign take      = held_valid && buf_free;

    atapio_in_reg u_in_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .is_write     (is_write),
        .drive        (drive),
        .lba          (lba),
        .sector_count (sector_count),
        .status       (status),
        .data         (data),
        .take         (take),
        .held_valid   (held_valid),
        .held_item    (held_item)
    );

    atapio_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .take      (take),
        .itm       (held_item),
        .res_list  (res_list),
        .res_n     (res_n)
    );

    atapio_res_buf u_res_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .load_list (res_list),
        .load_n    (res_n),
        .free      (buf_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head),
        .head_last (last)
    );

    assign kind         = head.kind;
    assign port         = head.port;
    assign value        = head.value;
    assign success      = head.success;
    assign sectors_done = head.sectors_done;

    // a transaction that is not the last of its item leaves more behind
    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> out_valid)
        else $error("results of one item broken up");

    // after the last result, output only if a new item stepped in that cycle
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> (!out_valid || $past(take)))
        else $error("result appeared with no item behind it");

    a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (res_n <= RES_CNT_W'(MAX_RESULTS)))
        else $error("step produced too many results");

    a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
        (held_valid && !buf_free) |-> !in_ready)
        else $error("input taken while held item is blocked");

endmodule
